### rtl/assert_macros.svh
// assertion macros used by the top-level rtl file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, disabled while reset is asserted
`define SRBI_ASSERT_NOW(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("srbi assertion failed");

// next-cycle implication, disabled while reset is asserted
`define SRBI_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("srbi assertion failed");

`endif

### rtl/srbi_pkg.sv
// package: edge indices and helpers for the segment/rectangle boundary test
`default_nettype none

package srbi_pkg;

  // rectangle edges in test order: BL-TL, TL-TR, TR-BR, BR-BL
  localparam int unsigned NUM_EDGES   = 4;
  localparam int unsigned EDGE_LEFT   = 0;
  localparam int unsigned EDGE_TOP    = 1;
  localparam int unsigned EDGE_RIGHT  = 2;
  localparam int unsigned EDGE_BOTTOM = 3;

  // vertical edges have cdx == 0, horizontal edges have cdy == 0
  function automatic logic is_vertical(input int unsigned e);
    return (e == EDGE_LEFT) || (e == EDGE_RIGHT);
  endfunction

endpackage

`default_nettype wire

### rtl/segment_rect_boundary_intersect.sv
// top level: pipelined test of a 2-D segment against each edge of a rectangle
`default_nettype none

// One segment and one rectangle go in with each transfer (start_i high while busy_o
// is low); busy_o is tied low, so a new item can be taken on every clock. Each item
// gives exactly one result: hit_o, marked by done_o, registered through the pipeline
// stages below, in input order. The receiver cannot stall the output: hit_o is valid for
// exactly the one cycle in which done_o is high. The pipeline stages are the
// coordinate differences, the multiplier bank (four products per edge),
// the s-numerator subtraction, and the range compares with the final OR.
// Endpoint and corner touches count as hits; parallel or zero-length edges never hit.

`include "assert_macros.svh"

module segment_rect_boundary_intersect #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] seg_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] rect_left_i,
  input  wire logic signed [COORD_BITS-1:0] rect_right_i,
  input  wire logic signed [COORD_BITS-1:0] rect_bottom_i,
  input  wire logic signed [COORD_BITS-1:0] rect_top_i,
  output logic                              done_o,
  output logic                              hit_o
);
  import srbi_pkg::*;

  // difference, product and s-numerator widths
  localparam int unsigned DW = COORD_BITS + 1;
  localparam int unsigned MW = 2 * DW;
  localparam int unsigned PW = MW + 1;

  // never stalls
  assign busy_o = 1'b0;

  // range check num/den in [0,1] by sign and magnitude, den nonzero
  function automatic logic in_unit(input logic signed [PW-1:0] num,
                                   input logic signed [PW-1:0] den);
    logic r;
    if (den > 0) begin
      r = (num >= 0) && (num <= den);
    end else begin
      r = (num <= 0) && (num >= den);
    end
    return r;
  endfunction

  // sign-extended coordinates
  logic signed [DW-1:0] ax, ay, bx, by, lx, rx, by_b, ty;
  assign ax   = {seg_start_x_i[COORD_BITS-1], seg_start_x_i};
  assign ay   = {seg_start_y_i[COORD_BITS-1], seg_start_y_i};
  assign bx   = {seg_end_x_i[COORD_BITS-1], seg_end_x_i};
  assign by   = {seg_end_y_i[COORD_BITS-1], seg_end_y_i};
  assign lx   = {rect_left_i[COORD_BITS-1], rect_left_i};
  assign rx   = {rect_right_i[COORD_BITS-1], rect_right_i};
  assign by_b = {rect_bottom_i[COORD_BITS-1], rect_bottom_i};
  assign ty   = {rect_top_i[COORD_BITS-1], rect_top_i};

  // stage 1: differences; k is the edge component that is not fixed at zero, oriented so that
  // denom = m*k and t_num = n*k with m,n the matching ab / ac components
  logic                 v1_q;
  logic signed [DW-1:0] abx_q, aby_q;
  logic signed [DW-1:0] acx_q [NUM_EDGES];
  logic signed [DW-1:0] acy_q [NUM_EDGES];
  logic signed [DW-1:0] k_q   [NUM_EDGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= start_i && !busy_o;
    end
  end

  always_ff @(posedge clk_i) begin
    abx_q <= bx - ax;
    aby_q <= by - ay;
    acx_q[EDGE_LEFT]   <= lx - ax;
    acy_q[EDGE_LEFT]   <= by_b - ay;
    k_q[EDGE_LEFT]     <= ty - by_b;
    acx_q[EDGE_TOP]    <= lx - ax;
    acy_q[EDGE_TOP]    <= ty - ay;
    k_q[EDGE_TOP]      <= lx - rx;
    acx_q[EDGE_RIGHT]  <= rx - ax;
    acy_q[EDGE_RIGHT]  <= ty - ay;
    k_q[EDGE_RIGHT]    <= by_b - ty;
    acx_q[EDGE_BOTTOM] <= rx - ax;
    acy_q[EDGE_BOTTOM] <= by_b - ay;
    k_q[EDGE_BOTTOM]   <= rx - lx;
  end

  // stage 2: multiplier bank, four products per edge
  logic                 v2_q;
  logic signed [MW-1:0] den_q [NUM_EDGES];
  logic signed [MW-1:0] tn_q  [NUM_EDGES];
  logic signed [MW-1:0] sp1_q [NUM_EDGES];
  logic signed [MW-1:0] sp2_q [NUM_EDGES];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned e = 0; e < NUM_EDGES; e++) begin
      if (is_vertical(e)) begin
        den_q[e] <= abx_q * k_q[e];
        tn_q[e]  <= acx_q[e] * k_q[e];
      end else begin
        den_q[e] <= aby_q * k_q[e];
        tn_q[e]  <= acy_q[e] * k_q[e];
      end
      sp1_q[e] <= acx_q[e] * aby_q;
      sp2_q[e] <= acy_q[e] * abx_q;
    end
  end

  // stage 3: s numerator and denominator zero check
  logic                 v3_q;
  logic signed [PW-1:0] den3_q [NUM_EDGES];
  logic signed [PW-1:0] tn3_q  [NUM_EDGES];
  logic signed [PW-1:0] sn3_q  [NUM_EDGES];
  logic [NUM_EDGES-1:0] nz3_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v3_q <= 1'b0;
    end else begin
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int unsigned e = 0; e < NUM_EDGES; e++) begin
      den3_q[e] <= {den_q[e][MW-1], den_q[e]};
      tn3_q[e]  <= {tn_q[e][MW-1], tn_q[e]};
      sn3_q[e]  <= {sp1_q[e][MW-1], sp1_q[e]} - {sp2_q[e][MW-1], sp2_q[e]};
      nz3_q[e]  <= (den_q[e] != '0);
    end
  end

  // stage 4: range compares, or over edges, output register
  logic [NUM_EDGES-1:0] edge_hit;
  logic                 hit_d, hit_q;
  logic                 done_q;

  always_comb begin
    for (int unsigned e = 0; e < NUM_EDGES; e++) begin
      edge_hit[e] = nz3_q[e] && in_unit(tn3_q[e], den3_q[e])
                             && in_unit(sn3_q[e], den3_q[e]);
    end
    hit_d = v3_q && (|edge_hit);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      hit_q  <= 1'b0;
    end else begin
      done_q <= v3_q;
      hit_q  <= hit_d;
    end
  end

  assign done_o = done_q;
  assign hit_o  = hit_q;

  // every accepted item yields its result strobe at the end of the pipeline
  `SRBI_ASSERT_NEXT(a_latency, clk_i, rst_ni, start_i && !busy_o, ##3 done_o)
  // no result without an earlier accepted item at the pipeline input
  `SRBI_ASSERT_NOW(a_no_orphan, clk_i, rst_ni, done_o, $past(start_i, 4))
  // all edges parallel or degenerate means no hit
  `SRBI_ASSERT_NEXT(a_degen_no_hit, clk_i, rst_ni, v3_q && (nz3_q == '0), !hit_o)
  // hit is quiet outside the result strobe
  `SRBI_ASSERT_NOW(a_hit_quiet, clk_i, rst_ni, !done_o, !hit_o)

endmodule

`default_nettype wire

### dv/srbi_hit_monitor.sv
// checker for the segment/rectangle boundary test: predicts each hit flag and compares results
module srbi_hit_monitor #(
  parameter int unsigned COORD_BITS = 16
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  input  wire logic                         busy_i,
  input  wire logic signed [COORD_BITS-1:0] seg_start_x_i,
  input  wire logic signed [COORD_BITS-1:0] seg_start_y_i,
  input  wire logic signed [COORD_BITS-1:0] seg_end_x_i,
  input  wire logic signed [COORD_BITS-1:0] seg_end_y_i,
  input  wire logic signed [COORD_BITS-1:0] rect_left_i,
  input  wire logic signed [COORD_BITS-1:0] rect_right_i,
  input  wire logic signed [COORD_BITS-1:0] rect_bottom_i,
  input  wire logic signed [COORD_BITS-1:0] rect_top_i,
  input  wire logic                         done_i,
  input  wire logic                         hit_i,
  output int unsigned                       mismatch_count_o,
  output int unsigned                       hits_pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef logic signed [COORD_BITS-1:0] coord_t;

  bit          expected_hits[$];
  int unsigned mismatch_total;

  // ratio num/den within the closed unit range, den nonzero
  function automatic bit ratio_in_unit(input longint num, input longint den);
    if (den > 0) begin
      return (num >= 0) && (num <= den);
    end
    return (num <= 0) && (num >= den);
  endfunction

  // exact crossing test of segment a-b against one rectangle side c-d
  function automatic bit side_crossed(input longint ax, input longint ay,
                                      input longint bx, input longint by,
                                      input longint cx, input longint cy,
                                      input longint dx, input longint dy);
    longint abx, aby, cdx, cdy, acx, acy;
    longint den, t_num, s_num;
    abx   = bx - ax;
    aby   = by - ay;
    cdx   = dx - cx;
    cdy   = dy - cy;
    acx   = cx - ax;
    acy   = cy - ay;
    den   = abx * cdy - aby * cdx;
    t_num = acx * cdy - acy * cdx;
    s_num = acx * aby - acy * abx;
    if (den == 0) begin
      return 1'b0;
    end
    return ratio_in_unit(t_num, den) && ratio_in_unit(s_num, den);
  endfunction

  // sides in order left, top, right, bottom; corners used as given
  function automatic bit segment_crosses_rect(input coord_t ax, input coord_t ay,
                                              input coord_t bx, input coord_t by,
                                              input coord_t l, input coord_t r,
                                              input coord_t b, input coord_t t);
    longint sx, sy, ex, ey, lx, rx, by0, ty;
    sx  = longint'(ax);
    sy  = longint'(ay);
    ex  = longint'(bx);
    ey  = longint'(by);
    lx  = longint'(l);
    rx  = longint'(r);
    by0 = longint'(b);
    ty  = longint'(t);
    return side_crossed(sx, sy, ex, ey, lx, by0, lx, ty)
        || side_crossed(sx, sy, ex, ey, lx, ty, rx, ty)
        || side_crossed(sx, sy, ex, ey, rx, ty, rx, by0)
        || side_crossed(sx, sy, ex, ey, rx, by0, lx, by0);
  endfunction

  // predict on each input transfer, compare on each result strobe
  always @(posedge clk_i) begin
    bit want;
    if (!rst_ni) begin
      expected_hits.delete();
      mismatch_total = 0;
    end else begin
      if (done_i) begin
        if (expected_hits.size() == 0) begin
          $error("hit: result with no prediction pending, actual %0b", hit_i);
          mismatch_total++;
        end else begin
          want = expected_hits.pop_front();
          if (hit_i !== want) begin
            $error("hit: expected %0b, actual %0b", want, hit_i);
            mismatch_total++;
          end
        end
      end
      if (start_i && !busy_i) begin
        expected_hits.push_back(segment_crosses_rect(seg_start_x_i, seg_start_y_i,
                                                     seg_end_x_i, seg_end_y_i,
                                                     rect_left_i, rect_right_i,
                                                     rect_bottom_i, rect_top_i));
      end
    end
    mismatch_count_o <= mismatch_total;
    hits_pending_o   <= expected_hits.size();
  end

endmodule

### dv/tb.sv
// testbench top: drives segment/rectangle pairs into the block and gives the verdict
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned COORD_BITS = 16;
  localparam int unsigned RANDOM_PAIRS = 1450;

  logic                         clk   = 1'b0;
  logic                         rst_n = 1'b0;
  logic                         start = 1'b0;
  logic                         busy;
  logic                         done;
  logic                         hit;
  logic signed [COORD_BITS-1:0] seg_start_x = '0;
  logic signed [COORD_BITS-1:0] seg_start_y = '0;
  logic signed [COORD_BITS-1:0] seg_end_x   = '0;
  logic signed [COORD_BITS-1:0] seg_end_y   = '0;
  logic signed [COORD_BITS-1:0] rect_left   = '0;
  logic signed [COORD_BITS-1:0] rect_right  = '0;
  logic signed [COORD_BITS-1:0] rect_bottom = '0;
  logic signed [COORD_BITS-1:0] rect_top    = '0;
  int unsigned                  mismatch_count;
  int unsigned                  hits_pending;
  bit                           gaps_on = 1'b1;

  segment_rect_boundary_intersect #(.COORD_BITS(COORD_BITS)) dut (
    .clk_i         (clk),
    .rst_ni        (rst_n),
    .start_i       (start),
    .busy_o        (busy),
    .seg_start_x_i (seg_start_x),
    .seg_start_y_i (seg_start_y),
    .seg_end_x_i   (seg_end_x),
    .seg_end_y_i   (seg_end_y),
    .rect_left_i   (rect_left),
    .rect_right_i  (rect_right),
    .rect_bottom_i (rect_bottom),
    .rect_top_i    (rect_top),
    .done_o        (done),
    .hit_o         (hit)
  );

  srbi_hit_monitor #(.COORD_BITS(COORD_BITS)) hit_monitor (
    .clk_i            (clk),
    .rst_ni           (rst_n),
    .start_i          (start),
    .busy_i           (busy),
    .seg_start_x_i    (seg_start_x),
    .seg_start_y_i    (seg_start_y),
    .seg_end_x_i      (seg_end_x),
    .seg_end_y_i      (seg_end_y),
    .rect_left_i      (rect_left),
    .rect_right_i     (rect_right),
    .rect_bottom_i    (rect_bottom),
    .rect_top_i       (rect_top),
    .done_i           (done),
    .hit_i            (hit),
    .mismatch_count_o (mismatch_count),
    .hits_pending_o   (hits_pending)
  );

  // 8 ns clock
  initial begin
    forever #4 clk = ~clk;
  end

  // hard stop in case the block hangs or drops results
  initial begin
    #2_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // coordinate near the origin, so touches and overlaps are common
  function automatic int near_coord();
    return int'($urandom_range(0, 128)) - 64;
  endfunction

  // mostly small coordinates, sometimes the full range
  function automatic int base_coord();
    if ($urandom_range(0, 3) == 0) begin
      return int'($signed(COORD_BITS'($urandom)));
    end
    return near_coord();
  endfunction

  // endpoint coordinate snapped to a rectangle bound, its middle, or free
  function automatic int snap_coord(input int lo, input int hi);
    case ($urandom_range(0, 3))
      0: begin
        return lo;
      end
      1: begin
        return hi;
      end
      2: begin
        return (lo + hi) / 2;
      end
      default: begin
        return base_coord();
      end
    endcase
  endfunction

  // one input transfer after a random gap; start stays high across back-to-back items
  task automatic send_pair(input int ax, input int ay, input int bx, input int by,
                           input int l, input int r, input int b, input int t);
    int gap;
    gap = gaps_on ? int'($urandom_range(0, 10)) : 0;
    repeat (gap) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start       <= 1'b1;
    seg_start_x <= ax[COORD_BITS-1:0];
    seg_start_y <= ay[COORD_BITS-1:0];
    seg_end_x   <= bx[COORD_BITS-1:0];
    seg_end_y   <= by[COORD_BITS-1:0];
    rect_left   <= l[COORD_BITS-1:0];
    rect_right  <= r[COORD_BITS-1:0];
    rect_bottom <= b[COORD_BITS-1:0];
    rect_top    <= t[COORD_BITS-1:0];
    @(posedge clk);
    while (busy) begin
      @(posedge clk);
    end
  endtask

  // stimulus and verdict
  initial begin
    int kind;
    int l, r, b, t;
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed: degenerate inputs
    send_pair(0, 0, 0, 0, 0, 0, 0, 0);
    send_pair(-200, 0, 200, 0, 0, 0, 0, 0);
    // clean crossing, wholly inside, wholly outside
    send_pair(-200, 0, 200, 0, -100, 100, -100, 100);
    send_pair(-50, -20, 40, 30, -100, 100, -100, 100);
    send_pair(150, 150, 300, 220, -100, 100, -100, 100);
    // endpoint on a corner and on a side
    send_pair(100, 100, 200, 200, -100, 100, -100, 100);
    send_pair(100, 0, 200, 0, -100, 100, -100, 100);
    // collinear overlap with the top side only
    send_pair(-50, 100, 50, 100, -100, 100, -100, 100);
    // collinear through both top corners
    send_pair(-200, 100, 200, 100, -100, 100, -100, 100);
    // zero-length segment sitting on a side
    send_pair(100, 0, 100, 0, -100, 100, -100, 100);
    // inverted rectangle
    send_pair(-200, 0, 200, 0, 100, -100, 100, -100);
    send_pair(0, -200, 0, 200, 100, -100, -100, 100);
    // extremes of the coordinate range
    send_pair(-32768, -32768, 32767, 32767, -32768, 32767, -32768, 32767);
    send_pair(-32768, 32767, 32767, -32768, 0, 0, 0, 0);
    send_pair(-32768, 0, 32767, 0, -32768, 32767, -32768, 32767);
    send_pair(32767, 32767, 32767, 32767, 32767, 32767, 32767, 32767);
    send_pair(-32768, -32768, -32768, -32768, -32768, -32768, -32768, -32768);
    send_pair(32767, -32768, -32768, 32767, -1, 1, -1, 1);
    // alternating bit patterns
    send_pair('h5555, 'haaaa, 'haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa, 'h5555);
    send_pair('haaaa, 'h5555, 'h5555, 'haaaa, 'h5555, 'haaaa, 'h5555, 'haaaa);

    // random pairs: free, near the origin, and snapped to the rectangle
    for (int i = 0; i < RANDOM_PAIRS; i++) begin
      if ($urandom_range(0, 39) == 0) begin
        gaps_on = !gaps_on;
      end
      kind = $urandom_range(0, 9);
      if (kind < 3) begin
        send_pair(int'($urandom), int'($urandom), int'($urandom), int'($urandom),
                  int'($urandom), int'($urandom), int'($urandom), int'($urandom));
      end else if (kind < 7) begin
        send_pair(near_coord(), near_coord(), near_coord(), near_coord(),
                  near_coord(), near_coord(), near_coord(), near_coord());
      end else begin
        l = base_coord();
        r = base_coord();
        b = base_coord();
        t = base_coord();
        // keep most rectangles upright
        if ($urandom_range(0, 4) != 0) begin
          if (l > r) begin
            l = l ^ r;
            r = l ^ r;
            l = l ^ r;
          end
          if (b > t) begin
            b = b ^ t;
            t = b ^ t;
            b = b ^ t;
          end
        end
        send_pair(snap_coord(l, r), snap_coord(b, t), snap_coord(l, r), snap_coord(b, t),
                  l, r, b, t);
      end
    end
    start <= 1'b0;

    // drain outstanding results, then let the pipeline settle
    @(posedge clk);
    while (hits_pending != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
